// ===== sv/cpcd_pkg.sv =====
// cpcd_pkg: shared types, codes and the crc16 byte update for the pixel command deframer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package cpcd_pkg;

  // frame layout
  localparam int unsigned BODY_LEN = 5;
  localparam int unsigned POS_W    = 3;

  // byte positions within a frame
  localparam logic [POS_W-1:0] POS_HUNT    = 3'd0;
  localparam logic [POS_W-1:0] POS_CMD     = 3'd1;
  localparam logic [POS_W-1:0] POS_IDX     = 3'd2;
  localparam logic [POS_W-1:0] POS_RED     = 3'd3;
  localparam logic [POS_W-1:0] POS_GREEN   = 3'd4;
  localparam logic [POS_W-1:0] POS_BLUE    = 3'd5;
  localparam logic [POS_W-1:0] POS_CRC_LO  = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_HI  = 3'd7;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SET_PIXEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH      = 3'd4;

  // configuration reset values
  localparam logic [7:0]  MAGIC_RST     = 8'hAA;
  localparam logic [15:0] CRC_SEED_RST  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_RST  = 16'h1021;
  localparam logic [7:0]  SET_PIXEL_RST = 8'h01;
  localparam logic [7:0]  FLUSH_RST     = 8'h02;

  typedef enum logic [1:0] {
    EV_SET_PIXEL = 2'd0,
    EV_FLUSH     = 2'd1,
    EV_BAD_CMD   = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [7:0]  magic;
    logic [15:0] seed;
    logic [15:0] poly;
    logic [7:0]  set_pixel_code;
    logic [7:0]  flush_code;
  } cfg_t;

  // checked frame handed from front to back
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } frame_t;

  // crc16 msb-first update over one byte, top bit of the polynomial implicit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/cpcd_front.sv =====
// cpcd_front: magic hunt, frame byte capture and crc check
// depends on cpcd_pkg; hands good frames to the frame queue
`timescale 1ns / 1ps

module cpcd_front (
  input  logic                clk,
  input  logic                rst,
  input  cpcd_pkg::cfg_t      cfg,
  input  logic                byte_beat,
  input  logic [7:0]          rx_byte,
  output logic                frame_push,
  output cpcd_pkg::frame_t    frame
);

  logic [cpcd_pkg::POS_W-1:0] byte_position;
  logic [15:0]                running_crc;
  logic [7:0]                 checksum_low;
  cpcd_pkg::frame_t           body;
  logic [15:0]                crc_in;
  logic [15:0]                crc_upd;

  // crc source: seed on the magic byte, running value otherwise
  assign crc_in  = (byte_position == cpcd_pkg::POS_HUNT) ? cfg.seed : running_crc;
  assign crc_upd = cpcd_pkg::crc_byte(crc_in, rx_byte, cfg.poly);

  // good frame leaves on its last byte when the checksum matches
  assign frame_push = byte_beat && (byte_position == cpcd_pkg::POS_CRC_HI) &&
                      ({rx_byte, checksum_low} == running_crc);
  assign frame = body;

  // position counter and crc
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= cpcd_pkg::POS_HUNT;
      running_crc   <= cpcd_pkg::CRC_SEED_RST;
    end else if (byte_beat) begin
      case (byte_position)
        cpcd_pkg::POS_HUNT: begin
          if (rx_byte == cfg.magic) begin
            byte_position <= cpcd_pkg::POS_CMD;
            running_crc   <= crc_upd;
          end
        end
        cpcd_pkg::POS_CMD, cpcd_pkg::POS_IDX, cpcd_pkg::POS_RED,
        cpcd_pkg::POS_GREEN, cpcd_pkg::POS_BLUE: begin
          byte_position <= byte_position + 3'd1;
          running_crc   <= crc_upd;
        end
        cpcd_pkg::POS_CRC_LO: byte_position <= cpcd_pkg::POS_CRC_HI;
        default:              byte_position <= cpcd_pkg::POS_HUNT;
      endcase
    end
  end

  // frame body and low checksum byte capture
  always_ff @(posedge clk) begin
    if (byte_beat) begin
      case (byte_position)
        cpcd_pkg::POS_CMD:    body.cmd       <= rx_byte;
        cpcd_pkg::POS_IDX:    body.led_index <= rx_byte;
        cpcd_pkg::POS_RED:    body.red       <= rx_byte;
        cpcd_pkg::POS_GREEN:  body.green     <= rx_byte;
        cpcd_pkg::POS_BLUE:   body.blue      <= rx_byte;
        cpcd_pkg::POS_CRC_LO: checksum_low   <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/cpcd_fifo.sv =====
// cpcd_fifo: two-entry queue of checked frames between front and back
// depends on cpcd_pkg
`timescale 1ns / 1ps

module cpcd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cpcd_pkg::frame_t  wr_frame,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output cpcd_pkg::frame_t  rd_frame
);

  cpcd_pkg::frame_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign rd_frame = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_frame;
  end

endmodule

// ===== sv/cpcd_back.sv =====
// cpcd_back: command decode and result output register
// depends on cpcd_pkg; takes frames from the frame queue
`timescale 1ns / 1ps

module cpcd_back (
  input  logic              clk,
  input  logic              rst,
  input  cpcd_pkg::cfg_t    cfg,
  input  logic              frame_valid,
  input  cpcd_pkg::frame_t  frame,
  output logic              frame_pop,
  output logic              out_valid,
  input  logic              out_beat,
  output logic [1:0]        event_kind,
  output logic [7:0]        led_index,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);

  logic load;

  // output register takes a frame when empty or being drained
  assign load      = frame_valid && (!out_valid || out_beat);
  assign frame_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  // decode: set pixel takes priority over flush
  always_ff @(posedge clk) begin
    if (load) begin
      if (frame.cmd == cfg.set_pixel_code) begin
        event_kind <= cpcd_pkg::EV_SET_PIXEL;
        led_index  <= frame.led_index;
        red        <= frame.red;
        green      <= frame.green;
        blue       <= frame.blue;
      end else begin
        event_kind <= (frame.cmd == cfg.flush_code) ? cpcd_pkg::EV_FLUSH
                                                    : cpcd_pkg::EV_BAD_CMD;
        led_index  <= 8'd0;
        red        <= 8'd0;
        green      <= 8'd0;
        blue       <= 8'd0;
      end
    end
  end

endmodule

// ===== sv/crc_checked_pixel_command_deframer_unit.sv =====
// crc_checked_pixel_command_deframer_unit: top level of the pixel command deframer
// depends on cpcd_pkg, cpcd_front, cpcd_fifo, cpcd_back
`timescale 1ns / 1ps

// Usage
//   Bytes from the serial receiver enter on rx_byte with push; a beat is taken
//   when push is high and full is low. One byte per cycle while full is low.
//   Results leave as a queue: while empty is low the oldest event sits on
//   event_kind/led_index/red/green/blue and is taken when pop is high.
//   A frame is magic, command, four payload bytes and a little-endian crc16;
//   bad-crc frames vanish, good ones give one event.
//   The edge that takes the last frame byte writes the frame queue; the decode
//   register loads it from the queue when it is empty or being drained.
//   The front checks the crc one byte per cycle while full is low; a frame
//   queue of two entries and the output register sit behind it, so full
//   only rises when the receiver holds off popping for more than two frames.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high, indexes past the register list are ignored. Write only
//   while the block is idle.
//   Reset (rst, synchronous): hunting for magic, queues empty, registers at
//   their defaults (magic 0xAA, seed 0xFFFF, poly 0x1021, codes 1 and 2).

module crc_checked_pixel_command_deframer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       rx_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       event_kind,
  output logic [7:0]                       led_index,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cpcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data
);

  cpcd_pkg::cfg_t   cfg;
  cpcd_pkg::frame_t push_frame;
  cpcd_pkg::frame_t pop_frame;
  logic             byte_beat;
  logic             frame_push;
  logic             frame_pop;
  logic             frame_valid;
  logic             out_valid;
  logic             q_full;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign byte_beat = push && !q_full;
  assign empty     = !out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic          <= cpcd_pkg::MAGIC_RST;
      cfg.seed           <= cpcd_pkg::CRC_SEED_RST;
      cfg.poly           <= cpcd_pkg::CRC_POLY_RST;
      cfg.set_pixel_code <= cpcd_pkg::SET_PIXEL_RST;
      cfg.flush_code     <= cpcd_pkg::FLUSH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpcd_pkg::REG_MAGIC:     cfg.magic          <= cfg_data[7:0];
        cpcd_pkg::REG_CRC_SEED:  cfg.seed           <= cfg_data;
        cpcd_pkg::REG_CRC_POLY:  cfg.poly           <= cfg_data;
        cpcd_pkg::REG_SET_PIXEL: cfg.set_pixel_code <= cfg_data[7:0];
        cpcd_pkg::REG_FLUSH:     cfg.flush_code     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // byte framing and crc check
  cpcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_beat  (byte_beat),
    .rx_byte    (rx_byte),
    .frame_push (frame_push),
    .frame      (push_frame)
  );

  // checked frame queue
  cpcd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (frame_push),
    .wr_frame (push_frame),
    .full     (q_full),
    .pop      (frame_pop),
    .valid    (frame_valid),
    .rd_frame (pop_frame)
  );

  // command decode and result register
  cpcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_valid (frame_valid),
    .frame       (pop_frame),
    .frame_pop   (frame_pop),
    .out_valid   (out_valid),
    .out_beat    (pop && out_valid),
    .event_kind  (event_kind),
    .led_index   (led_index),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

endmodule
